// File: rtl/bc_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared widths, register indexes, status codes, pipeline types and the
// calibration CRC step functions.
// ----------------------------------------------------------------------------
package bc_pkg;

  localparam int RAW_W      = 24;
  localparam int WORD_W     = 16;
  localparam int NUM_WORDS  = 8;
  localparam int IDX_W      = 3;
  localparam int TEMP_W     = 20;
  localparam int PRES_W     = 32;
  localparam int STATUS_W   = 2;

  localparam int DT_W       = 25;
  localparam int TPROD_W    = 42;
  localparam int DTSQ_W     = 49;
  localparam int LIN_W      = 42;
  localparam int A_W        = 19;
  localparam int T2_W       = 18;
  localparam int SQ_W       = 40;
  localparam int PROD_W     = 46;
  localparam int WIDE_W     = 48;
  localparam int SPLIT      = 21;
  localparam int PHI_W      = 52;
  localparam int PLO_W      = 45;
  localparam int DIFF_W     = 53;

  localparam int C5_SHIFT      = 8;
  localparam int TEMP_SHIFT    = 23;
  localparam int T2_COLD_SHIFT = 33;
  localparam int T2_WARM_SHIFT = 38;
  localparam int C2_SHIFT      = 16;
  localparam int C1_SHIFT      = 15;
  localparam int OFF_SHIFT     = 7;
  localparam int SENS_SHIFT    = 8;
  localparam int DIV16_SHIFT   = 4;
  localparam int PRES_SHIFT    = 15;

  localparam int CRC_STAGES = 4;
  localparam int CRC_W      = 4;

  localparam logic [IDX_W-1:0] IDX_PROM0 = 3'd0;
  localparam logic [IDX_W-1:0] IDX_C1    = 3'd1;
  localparam logic [IDX_W-1:0] IDX_C2    = 3'd2;
  localparam logic [IDX_W-1:0] IDX_C3    = 3'd3;
  localparam logic [IDX_W-1:0] IDX_C4    = 3'd4;
  localparam logic [IDX_W-1:0] IDX_C5    = 3'd5;
  localparam logic [IDX_W-1:0] IDX_C6    = 3'd6;
  localparam logic [IDX_W-1:0] IDX_PROM7 = 3'd7;

  localparam logic signed [TEMP_W-1:0] TEMP_REF   = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VCOLD = 20'sd1500;

  localparam logic [5:0] K_OFF2_COLD   = 6'd61;
  localparam logic [5:0] K_SENS2_COLD  = 6'd29;
  localparam logic [5:0] K_OFF2_VCOLD  = 6'd17;
  localparam logic [5:0] K_SENS2_VCOLD = 6'd9;

  localparam logic [WORD_W-1:0] CRC_POLY = 16'h3000;
  localparam logic [WORD_W-1:0] CRC_KEEP = 16'hFF00;
  localparam logic [WORD_W-1:0] CRC_INIT = 16'h0000;

  localparam logic signed [PRES_W-1:0] PRES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PRES_W-1:0] PRES_MIN = 32'sh8000_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_CRC  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] prom_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] off_base;
    logic signed [WIDE_W-1:0] sens_base;
    logic [SQ_W-1:0]          asq;
    logic [SQ_W-1:0]          csq;
    logic                     cold;
    logic                     vcold;
    logic signed [TEMP_W-1:0] tc;
    logic [RAW_W-1:0]         d1;
    logic                     zero;
  } mid_t;

  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] rem,
                                                 input logic [7:0] data);
    logic [WORD_W-1:0] r;
    r = rem ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      r = r[WORD_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] crc_word(input logic [WORD_W-1:0] rem,
                                                 input logic [WORD_W-1:0] word);
    return crc_byte(crc_byte(rem, word[WORD_W-1:8]), word[7:0]);
  endfunction

endpackage

// File: rtl/bc_ifs.sv
// ----------------------------------------------------------------------------
// Barometer compensation channel interfaces
// Valid/ready channels for raw sample pairs and compensated results.
// ----------------------------------------------------------------------------
interface bc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bc_pkg::RAW_W-1:0]    raw_temperature;
  logic [bc_pkg::RAW_W-1:0]    raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bc_pkg::TEMP_W-1:0]  temperature_centi;
  logic signed [bc_pkg::PRES_W-1:0]  pressure_centi;
  logic [bc_pkg::STATUS_W-1:0]       status;

  modport source (output valid, temperature_centi, pressure_centi, status, input ready);
  modport sink   (input valid, temperature_centi, pressure_centi, status, output ready);
endinterface

// File: rtl/barometer_compensation.sv
// ----------------------------------------------------------------------------
// Barometer compensation top level
// Compensates raw temperature and pressure conversions with the factory
// calibration words and checks the calibration CRC.
//
//   Channel   Direction  Payload                                    Transfer
//   in_chan   sink       raw_temperature, raw_pressure              valid & ready
//   out_chan  source     temperature_centi, pressure_centi, status  valid & ready
//   cfg_*     sink       cfg_index, cfg_wdata                       cfg_we
//
// One sample pair is taken every cycle while out_chan is ready; each result passes
// through the nine register stages of the multiplier pipeline. The CRC verdict
// follows a calibration write through the word, CRC stage and verdict registers.
// Synchronous reset clears the stage valid bits and the calibration words.
// A stalled output holds every stage that is full; empty stages still fill.
// ----------------------------------------------------------------------------
module barometer_compensation (
  input  logic                        clk,
  input  logic                        rst_n,
  bc_in_if.sink                       in_chan,
  bc_out_if.source                    out_chan,
  input  logic                        cfg_we,
  input  logic [bc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bc_pkg::WORD_W-1:0]   cfg_wdata
);

  bc_pkg::prom_t prom_r, prom_nxt;
  logic          crc_ok;
  logic          mid_valid;
  logic          mid_ready;
  bc_pkg::mid_t  mid;

  always_comb begin
    prom_nxt = prom_r;
    if (cfg_we) begin
      prom_nxt[cfg_index] = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prom_r <= '0;
    end else begin
      prom_r <= prom_nxt;
    end
  end

  bc_crc u_crc (
    .clk    (clk),
    .prom   (prom_r),
    .crc_ok (crc_ok)
  );

  bc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .prom      (prom_r),
    .in_chan   (in_chan),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  bc_press u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .crc_ok    (crc_ok),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .out_chan  (out_chan)
  );

endmodule

// File: rtl/bc_crc.sv
// ----------------------------------------------------------------------------
// Calibration CRC chain
// Four register stages fold the calibration words into the 4-bit check.
// ----------------------------------------------------------------------------
module bc_crc (
  input  logic          clk,
  input  bc_pkg::prom_t prom,
  output logic          crc_ok
);

  bc_pkg::prom_t words;
  logic [bc_pkg::CRC_STAGES-1:0][bc_pkg::WORD_W-1:0] rem_r;
  logic [bc_pkg::CRC_STAGES-1:0][bc_pkg::WORD_W-1:0] rem_nxt;
  logic crc_ok_r;
  logic crc_ok_nxt;

  always_comb begin
    words = prom;
    words[bc_pkg::IDX_PROM7] = prom[bc_pkg::IDX_PROM7] & bc_pkg::CRC_KEEP;
  end

  for (genvar s = 0; s < bc_pkg::CRC_STAGES; s++) begin : g_stage
    logic [bc_pkg::WORD_W-1:0] prev;
    if (s == 0) begin : g_first
      assign prev = bc_pkg::CRC_INIT;
    end else begin : g_next
      assign prev = rem_r[s-1];
    end
    assign rem_nxt[s] = bc_pkg::crc_word(bc_pkg::crc_word(prev, words[2*s]),
                                         words[2*s+1]);
  end

  assign crc_ok_nxt = rem_r[bc_pkg::CRC_STAGES-1][bc_pkg::WORD_W-1 -: bc_pkg::CRC_W] ==
                      prom[bc_pkg::IDX_PROM7][bc_pkg::CRC_W-1:0];

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    crc_ok_r <= crc_ok_nxt;
  end

  assign crc_ok = crc_ok_r;

endmodule

// File: rtl/bc_temp.sv
// ----------------------------------------------------------------------------
// Temperature and coefficient pipeline
// Four stages: dT, the products on dT, TEMP with T2 and the offset and
// sensitivity bases, then the squares for the second-order terms.
// ----------------------------------------------------------------------------
module bc_temp (
  input  logic          clk,
  input  logic          rst_n,
  input  bc_pkg::prom_t prom,
  bc_in_if.sink         in_chan,
  output logic          mid_valid,
  input  logic          mid_ready,
  output bc_pkg::mid_t  mid
);

  localparam int NUM_STAGES = 4;
  localparam int WIDE_W     = bc_pkg::WIDE_W;
  localparam int SQ_W       = bc_pkg::SQ_W;
  localparam int T2_W       = bc_pkg::T2_W;
  localparam int TEMP_W     = bc_pkg::TEMP_W;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES:0]   rdy;

  logic signed [bc_pkg::DT_W-1:0]     dt_r, dt_nxt;
  logic [bc_pkg::RAW_W-1:0]           d1_s1_r;
  logic                               zero_s1_r, zero_nxt;

  logic signed [bc_pkg::TPROD_W-1:0]  tprod_r, tprod_nxt;
  logic signed [2*bc_pkg::DT_W-1:0]   dt_sq;
  logic [bc_pkg::DTSQ_W-1:0]          dtsq_r, dtsq_nxt;
  logic signed [bc_pkg::LIN_W-1:0]    offl_r, offl_nxt;
  logic signed [bc_pkg::LIN_W-1:0]    sensl_r, sensl_nxt;
  logic [bc_pkg::RAW_W-1:0]           d1_s2_r;
  logic                               zero_s2_r;

  logic signed [bc_pkg::A_W-1:0]      a_nxt, a_r;
  logic signed [TEMP_W-1:0]           temp_nxt, temp_r;
  logic signed [TEMP_W-1:0]           c_nxt, c_r;
  logic                               cold_nxt, cold_r;
  logic                               vcold_nxt, vcold_r;
  logic [bc_pkg::DTSQ_W+1:0]          sq3, sq5;
  logic [T2_W-1:0]                    t2_nxt, t2_r;
  logic signed [WIDE_W-1:0]           off_base_nxt, off_base_r;
  logic signed [WIDE_W-1:0]           sens_base_nxt, sens_base_r;
  logic [bc_pkg::RAW_W-1:0]           d1_s3_r;
  logic                               zero_s3_r;

  logic signed [2*bc_pkg::A_W-1:0]    a_sq;
  logic signed [2*TEMP_W-1:0]         c_sq;
  bc_pkg::mid_t                       mid_nxt, mid_r;

  always_comb begin
    rdy[NUM_STAGES] = mid_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = (rdy[NUM_STAGES-1:0] & {vld_r[NUM_STAGES-2:0], in_chan.valid}) |
              (~rdy[NUM_STAGES-1:0] & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_chan.ready = rst_n & rdy[0];

  always_comb begin
    dt_nxt   = $signed({1'b0, in_chan.raw_temperature}) -
               $signed({1'b0, prom[bc_pkg::IDX_C5], {bc_pkg::C5_SHIFT{1'b0}}});
    zero_nxt = (in_chan.raw_temperature == '0) || (in_chan.raw_pressure == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dt_r      <= dt_nxt;
      d1_s1_r   <= in_chan.raw_pressure;
      zero_s1_r <= zero_nxt;
    end
  end

  always_comb begin
    tprod_nxt = dt_r * $signed({1'b0, prom[bc_pkg::IDX_C6]});
    dt_sq     = dt_r * dt_r;
    dtsq_nxt  = dt_sq[bc_pkg::DTSQ_W-1:0];
    offl_nxt  = dt_r * $signed({1'b0, prom[bc_pkg::IDX_C4]});
    sensl_nxt = dt_r * $signed({1'b0, prom[bc_pkg::IDX_C3]});
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      tprod_r   <= tprod_nxt;
      dtsq_r    <= dtsq_nxt;
      offl_r    <= offl_nxt;
      sensl_r   <= sensl_nxt;
      d1_s2_r   <= d1_s1_r;
      zero_s2_r <= zero_s1_r;
    end
  end

  always_comb begin
    a_nxt     = tprod_r[bc_pkg::TPROD_W-1:bc_pkg::TEMP_SHIFT];
    temp_nxt  = TEMP_W'(a_nxt) + bc_pkg::TEMP_REF;
    c_nxt     = temp_nxt + bc_pkg::TEMP_VCOLD;
    cold_nxt  = a_nxt[bc_pkg::A_W-1];
    vcold_nxt = c_nxt[TEMP_W-1];
    sq3       = {1'b0, dtsq_r, 1'b0} + {2'b00, dtsq_r};
    sq5       = {dtsq_r, 2'b00} + {2'b00, dtsq_r};
    if (cold_nxt) begin
      t2_nxt = sq3[bc_pkg::DTSQ_W+1:bc_pkg::T2_COLD_SHIFT];
    end else begin
      t2_nxt = T2_W'(sq5[bc_pkg::DTSQ_W+1:bc_pkg::T2_WARM_SHIFT]);
    end
    off_base_nxt  = $signed(WIDE_W'({prom[bc_pkg::IDX_C2], {bc_pkg::C2_SHIFT{1'b0}}})) +
                    WIDE_W'(offl_r >>> bc_pkg::OFF_SHIFT);
    sens_base_nxt = $signed(WIDE_W'({prom[bc_pkg::IDX_C1], {bc_pkg::C1_SHIFT{1'b0}}})) +
                    WIDE_W'(sensl_r >>> bc_pkg::SENS_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      a_r         <= a_nxt;
      temp_r      <= temp_nxt;
      c_r         <= c_nxt;
      cold_r      <= cold_nxt;
      vcold_r     <= vcold_nxt;
      t2_r        <= t2_nxt;
      off_base_r  <= off_base_nxt;
      sens_base_r <= sens_base_nxt;
      d1_s3_r     <= d1_s2_r;
      zero_s3_r   <= zero_s2_r;
    end
  end

  always_comb begin
    a_sq              = a_r * a_r;
    c_sq              = c_r * c_r;
    mid_nxt.off_base  = off_base_r;
    mid_nxt.sens_base = sens_base_r;
    mid_nxt.asq       = SQ_W'($unsigned(a_sq));
    mid_nxt.csq       = $unsigned(c_sq);
    mid_nxt.cold      = cold_r;
    mid_nxt.vcold     = vcold_r;
    mid_nxt.tc        = temp_r - $signed({2'b00, t2_r});
    mid_nxt.d1        = d1_s3_r;
    mid_nxt.zero      = zero_s3_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_valid = vld_r[NUM_STAGES-1];
  assign mid       = mid_r;

endmodule

// File: rtl/bc_press.sv
// ----------------------------------------------------------------------------
// Pressure pipeline
// Five stages: second-order terms, OFF and SENS, the split D1 * SENS
// product, the difference, then the shift, saturation and status.
// ----------------------------------------------------------------------------
module bc_press (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          crc_ok,
  input  logic          mid_valid,
  output logic          mid_ready,
  input  bc_pkg::mid_t  mid,
  bc_out_if.source      out_chan
);

  localparam int NUM_STAGES = 5;
  localparam int WIDE_W     = bc_pkg::WIDE_W;
  localparam int DIFF_W     = bc_pkg::DIFF_W;
  localparam int PRES_W     = bc_pkg::PRES_W;
  localparam int SH_W       = DIFF_W - bc_pkg::PRES_SHIFT;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES:0]   rdy;

  logic [bc_pkg::PROD_W-1:0]            asq61, asq29, csq17, csq9;
  logic [WIDE_W-1:0]                    off2_nxt, off2_r;
  logic [WIDE_W-1:0]                    sens2_nxt, sens2_r;
  bc_pkg::mid_t                         s5_r;

  logic signed [WIDE_W-1:0]             off_nxt, off_r;
  logic signed [WIDE_W-1:0]             sens_nxt, sens_r;
  logic [bc_pkg::RAW_W-1:0]             d1_s6_r;
  logic                                 zero_s6_r;
  logic signed [bc_pkg::TEMP_W-1:0]     tc_s6_r;

  logic signed [bc_pkg::PHI_W-1:0]      phi_nxt, phi_r;
  logic [bc_pkg::PLO_W-1:0]             plo_nxt, plo_r;
  logic signed [WIDE_W-1:0]             off_s7_r;
  logic                                 zero_s7_r;
  logic signed [bc_pkg::TEMP_W-1:0]     tc_s7_r;

  logic signed [DIFF_W-1:0]             diff_nxt, diff_r;
  logic                                 zero_s8_r;
  logic signed [bc_pkg::TEMP_W-1:0]     tc_s8_r;

  logic signed [SH_W-1:0]               sh;
  logic signed [PRES_W-1:0]             sat;
  logic signed [bc_pkg::TEMP_W-1:0]     temp_out_nxt, temp_out_r;
  logic signed [PRES_W-1:0]             pres_out_nxt, pres_out_r;
  bc_pkg::status_t                      status_nxt, status_r;

  always_comb begin
    rdy[NUM_STAGES] = out_chan.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = (rdy[NUM_STAGES-1:0] & {vld_r[NUM_STAGES-2:0], mid_valid}) |
              (~rdy[NUM_STAGES-1:0] & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign mid_ready = rdy[0];

  always_comb begin
    asq61 = mid.asq * bc_pkg::K_OFF2_COLD;
    asq29 = mid.asq * bc_pkg::K_SENS2_COLD;
    csq17 = mid.csq * bc_pkg::K_OFF2_VCOLD;
    csq9  = mid.csq * bc_pkg::K_SENS2_VCOLD;
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (mid.cold) begin
      off2_nxt  = WIDE_W'(asq61 >> bc_pkg::DIV16_SHIFT);
      sens2_nxt = WIDE_W'(asq29 >> bc_pkg::DIV16_SHIFT);
      if (mid.vcold) begin
        off2_nxt  = off2_nxt + WIDE_W'(csq17);
        sens2_nxt = sens2_nxt + WIDE_W'(csq9);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      off2_r  <= off2_nxt;
      sens2_r <= sens2_nxt;
      s5_r    <= mid;
    end
  end

  always_comb begin
    off_nxt  = s5_r.off_base - $signed(off2_r);
    sens_nxt = s5_r.sens_base - $signed(sens2_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      off_r     <= off_nxt;
      sens_r    <= sens_nxt;
      d1_s6_r   <= s5_r.d1;
      zero_s6_r <= s5_r.zero;
      tc_s6_r   <= s5_r.tc;
    end
  end

  always_comb begin
    phi_nxt = $signed({1'b0, d1_s6_r}) * $signed(sens_r[WIDE_W-1:bc_pkg::SPLIT]);
    plo_nxt = d1_s6_r * sens_r[bc_pkg::SPLIT-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      phi_r     <= phi_nxt;
      plo_r     <= plo_nxt;
      off_s7_r  <= off_r;
      zero_s7_r <= zero_s6_r;
      tc_s7_r   <= tc_s6_r;
    end
  end

  always_comb begin
    diff_nxt = DIFF_W'(phi_r) + $signed(DIFF_W'(plo_r >> bc_pkg::SPLIT)) -
               DIFF_W'(off_s7_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      diff_r    <= diff_nxt;
      zero_s8_r <= zero_s7_r;
      tc_s8_r   <= tc_s7_r;
    end
  end

  always_comb begin
    sh = diff_r[DIFF_W-1:bc_pkg::PRES_SHIFT];
    if ((sh[SH_W-1:PRES_W-1] == '0) || (sh[SH_W-1:PRES_W-1] == '1)) begin
      sat = sh[PRES_W-1:0];
    end else if (sh[SH_W-1]) begin
      sat = bc_pkg::PRES_MIN;
    end else begin
      sat = bc_pkg::PRES_MAX;
    end
    if (!crc_ok) begin
      status_nxt   = bc_pkg::ST_CRC;
      temp_out_nxt = '0;
      pres_out_nxt = '0;
    end else if (zero_s8_r) begin
      status_nxt   = bc_pkg::ST_ZERO;
      temp_out_nxt = '0;
      pres_out_nxt = '0;
    end else begin
      status_nxt   = bc_pkg::ST_OK;
      temp_out_nxt = tc_s8_r;
      pres_out_nxt = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      temp_out_r <= temp_out_nxt;
      pres_out_r <= pres_out_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_chan.valid             = vld_r[NUM_STAGES-1];
  assign out_chan.temperature_centi = temp_out_r;
  assign out_chan.pressure_centi    = pres_out_r;
  assign out_chan.status            = status_r;

endmodule

// File: rtl/bc_checker.sv
// ----------------------------------------------------------------------------
// Barometer compensation port checker
// Watches the top-level ports for reset, error, stall and rate behavior.
// ----------------------------------------------------------------------------
module bc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [bc_pkg::TEMP_W-1:0]   temperature_centi,
  input logic signed [bc_pkg::PRES_W-1:0]   pressure_centi,
  input logic [bc_pkg::STATUS_W-1:0]        status
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != bc_pkg::ST_OK) |->
      (temperature_centi == '0) && (pressure_centi == '0))
    else $error("Nonzero result fields with an error status.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(temperature_centi) &&
      $stable(pressure_centi) && $stable(status))
    else $error("Result changed while stalled.");

  a_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("Input not ready while the output side is ready.");

endmodule

bind barometer_compensation bc_checker u_bc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .temperature_centi (out_chan.temperature_centi),
  .pressure_centi    (out_chan.pressure_centi),
  .status            (out_chan.status)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Drives raw temperature and pressure pairs through the block under several
// calibration sets: reset values, a typical factory set, all ones, sets with
// a broken CRC and many random sets. Every result is checked against a local
// fixed-point compensation model. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 30;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_SETS   = 12;
  localparam int PAIRS_PER_SET = 140;
  localparam logic [bc_pkg::RAW_W-1:0] RAW_MAX = {bc_pkg::RAW_W{1'b1}};

  typedef struct packed {
    logic [bc_pkg::RAW_W-1:0] d2;
    logic [bc_pkg::RAW_W-1:0] d1;
  } raw_pair_t;

  typedef struct packed {
    logic signed [bc_pkg::TEMP_W-1:0] temp;
    logic signed [bc_pkg::PRES_W-1:0] pres;
    bc_pkg::status_t                  status;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                       cfg_we;
  logic [bc_pkg::IDX_W-1:0]   cfg_index;
  logic [bc_pkg::WORD_W-1:0]  cfg_wdata;

  bc_in_if  in_chan ();
  bc_out_if out_chan ();

  barometer_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  bc_pkg::prom_t cal_word = '0;
  raw_pair_t     raw_pairs[$];
  reading_t      due_readings[$];
  reading_t      got_reading;
  reading_t      want_reading;
  raw_pair_t     next_pair;

  int cyc;
  int gap_left;
  int stall_left;
  int idle_cycles;
  int bad_readings;
  int readings_checked;
  int calib_sets;
  int ok_count;
  int crc_count;
  int zero_count;
  logic calm;

  assign calm = (cyc % 1024) < 160;

  function automatic logic [bc_pkg::CRC_W-1:0] calib_crc(input bc_pkg::prom_t w);
    logic [bc_pkg::WORD_W-1:0] rem;
    logic [bc_pkg::WORD_W-1:0] word;
    logic [7:0]                bval;
    rem = '0;
    for (int i = 0; i < 2 * bc_pkg::NUM_WORDS; i++) begin
      word = w[i / 2];
      if (i / 2 == bc_pkg::NUM_WORDS - 1) word = word & 16'hFF00;
      bval = (i % 2 == 1) ? word[7:0] : word[15:8];
      rem = rem ^ {8'h00, bval};
      for (int b = 0; b < 8; b++) begin
        rem = rem[bc_pkg::WORD_W-1] ? ((rem << 1) ^ 16'h3000) : (rem << 1);
      end
    end
    return rem[bc_pkg::WORD_W-1 -: bc_pkg::CRC_W];
  endfunction

  function automatic reading_t compensate(input logic [bc_pkg::RAW_W-1:0] d2_raw,
                                          input logic [bc_pkg::RAW_W-1:0] d1_raw);
    reading_t r;
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp_c, t2, off2, sens2, off, sens, p, a, c;
    r = '0;
    if (calib_crc(cal_word) != cal_word[bc_pkg::IDX_PROM7][bc_pkg::CRC_W-1:0]) begin
      r.status = bc_pkg::ST_CRC;
      return r;
    end
    if (d1_raw == '0 || d2_raw == '0) begin
      r.status = bc_pkg::ST_ZERO;
      return r;
    end
    d1 = d1_raw;
    d2 = d2_raw;
    c1 = cal_word[bc_pkg::IDX_C1];
    c2 = cal_word[bc_pkg::IDX_C2];
    c3 = cal_word[bc_pkg::IDX_C3];
    c4 = cal_word[bc_pkg::IDX_C4];
    c5 = cal_word[bc_pkg::IDX_C5];
    c6 = cal_word[bc_pkg::IDX_C6];
    dt = d2 - (c5 <<< 8);
    temp_c = 2000 + ((dt * c6) >>> 23);
    if (temp_c < 2000) begin
      a = temp_c - 2000;
      t2 = (3 * dt * dt) >>> 33;
      off2 = 61 * a * a / 16;
      sens2 = 29 * a * a / 16;
      if (temp_c < -1500) begin
        c = temp_c + 1500;
        off2 = off2 + 17 * c * c;
        sens2 = sens2 + 9 * c * c;
      end
    end else begin
      t2 = (5 * dt * dt) >>> 38;
      off2 = 0;
      sens2 = 0;
    end
    off = (c2 <<< 16) + ((c4 * dt) >>> 7) - off2;
    sens = (c1 <<< 15) + ((c3 * dt) >>> 8) - sens2;
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    if (p > bc_pkg::PRES_MAX) p = bc_pkg::PRES_MAX;
    if (p < bc_pkg::PRES_MIN) p = bc_pkg::PRES_MIN;
    c = temp_c - t2;
    r.temp = c[bc_pkg::TEMP_W-1:0];
    r.pres = p[bc_pkg::PRES_W-1:0];
    r.status = bc_pkg::ST_OK;
    return r;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [bc_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return bc_pkg::WORD_W'($urandom());
    endcase
  endfunction

  function automatic bc_pkg::prom_t seal(input bc_pkg::prom_t w, input bit corrupt);
    bc_pkg::prom_t s;
    s = w;
    s[bc_pkg::IDX_PROM7][bc_pkg::CRC_W-1:0] = calib_crc(s);
    if (corrupt) begin
      s[bc_pkg::IDX_PROM7][bc_pkg::CRC_W-1:0] = s[bc_pkg::IDX_PROM7][bc_pkg::CRC_W-1:0] ^
                                                bc_pkg::CRC_W'($urandom_range(1, 15));
    end
    return s;
  endfunction

  function automatic raw_pair_t random_pair();
    raw_pair_t pr;
    longint base, half, v;
    base = longint'(cal_word[bc_pkg::IDX_C5]) <<< 8;
    case ($urandom_range(0, 19))
      0: v = 0;
      1: v = RAW_MAX;
      2, 3, 4, 5: v = longint'($urandom_range(0, RAW_MAX));
      default: begin
        case ($urandom_range(0, 2))
          0: half = longint'(1) <<< 12;
          1: half = longint'(1) <<< 18;
          default: half = longint'(1) <<< 23;
        endcase
        v = base + longint'($urandom_range(0, 2 * half)) - half;
        if (v < 1) v = 1;
        if (v > RAW_MAX) v = RAW_MAX;
      end
    endcase
    pr.d2 = v[bc_pkg::RAW_W-1:0];
    case ($urandom_range(0, 19))
      0: pr.d1 = '0;
      1: pr.d1 = RAW_MAX;
      2: pr.d1 = bc_pkg::RAW_W'($urandom_range(1, 255));
      default: pr.d1 = bc_pkg::RAW_W'($urandom_range(0, RAW_MAX));
    endcase
    return pr;
  endfunction

  function automatic bit drained();
    return raw_pairs.size() == 0 && !in_chan.valid && due_readings.size() == 0;
  endfunction

  task automatic send_pair(input logic [bc_pkg::RAW_W-1:0] d2,
                           input logic [bc_pkg::RAW_W-1:0] d1);
    raw_pair_t pr;
    pr.d2 = d2;
    pr.d1 = d1;
    raw_pairs.push_back(pr);
  endtask

  task automatic load_calibration(input bc_pkg::prom_t words);
    while (!drained()) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < bc_pkg::NUM_WORDS; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= i[bc_pkg::IDX_W-1:0];
      cfg_wdata <= words[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    cal_word = words;
    calib_sets++;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(input string msg);
    bad_readings++;
    if (bad_readings <= 10) $display("error: %s", msg);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Driver: holds each pair until its transfer, then inserts an optional gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (gap_left == 0 && raw_pairs.size() != 0) begin
        next_pair = raw_pairs.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.raw_temperature <= next_pair.d2;
        in_chan.raw_pressure <= next_pair.d1;
        gap_left <= (calm || $urandom_range(0, 99) < 70) ? 0 : gap_len();
      end else begin
        in_chan.valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) stall_left <= gap_len();
    end
  end

  // Monitor: predicts on every input transfer and checks every output transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        due_readings.push_back(compensate(in_chan.raw_temperature, in_chan.raw_pressure));
      end
      if (out_chan.valid && out_chan.ready) begin
        got_reading.temp = out_chan.temperature_centi;
        got_reading.pres = out_chan.pressure_centi;
        got_reading.status = bc_pkg::status_t'(out_chan.status);
        if (due_readings.size() == 0) begin
          note_mismatch($sformatf("unexpected result temp %0d pres %0d status %0d",
                                  $signed(got_reading.temp), $signed(got_reading.pres),
                                  got_reading.status));
        end else begin
          want_reading = due_readings.pop_front();
          readings_checked++;
          case (want_reading.status)
            bc_pkg::ST_OK:  ok_count++;
            bc_pkg::ST_CRC: crc_count++;
            default:        zero_count++;
          endcase
          if (got_reading.temp !== want_reading.temp || got_reading.pres !== want_reading.pres
              || out_chan.status !== want_reading.status) begin
            note_mismatch($sformatf(
                "result %0d expected temp %0d pres %0d status %0d, got temp %0d pres %0d status %0d",
                readings_checked, $signed(want_reading.temp), $signed(want_reading.pres),
                want_reading.status, $signed(got_reading.temp), $signed(got_reading.pres),
                out_chan.status));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    bc_pkg::prom_t typical;
    bc_pkg::prom_t all_ones;
    bc_pkg::prom_t rand_set;
    logic [bc_pkg::RAW_W-1:0] ref_raw;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.raw_temperature = '0;
    in_chan.raw_pressure = '0;
    out_chan.ready = 1'b0;
    cyc = 0;
    gap_left = 0;
    stall_left = 0;
    idle_cycles = 0;
    bad_readings = 0;
    readings_checked = 0;
    calib_sets = 0;
    ok_count = 0;
    crc_count = 0;
    zero_count = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // Calibration words straight out of reset are all zero and pass the CRC.
    send_pair(24'd1, 24'd1);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(24'd0, 24'd5);

    typical = '0;
    typical[bc_pkg::IDX_PROM0] = 16'h00A5;
    typical[bc_pkg::IDX_C1] = 16'd40127;
    typical[bc_pkg::IDX_C2] = 16'd36924;
    typical[bc_pkg::IDX_C3] = 16'd23317;
    typical[bc_pkg::IDX_C4] = 16'd23282;
    typical[bc_pkg::IDX_C5] = 16'd33464;
    typical[bc_pkg::IDX_C6] = 16'd28312;
    typical[bc_pkg::IDX_PROM7] = 16'h5A00;
    load_calibration(seal(typical, 1'b0));
    ref_raw = bc_pkg::RAW_W'(longint'(typical[bc_pkg::IDX_C5]) <<< 8);
    send_pair(24'd8569781, 24'd9085466);
    send_pair(ref_raw, 24'd9085466);
    send_pair(ref_raw - 24'd1, 24'd9085466);
    send_pair(ref_raw - 24'd200000, RAW_MAX);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(24'd1, RAW_MAX);
    send_pair(24'd1, 24'd1);
    send_pair(24'd0, 24'd100);
    send_pair(24'd100, 24'd0);
    send_pair(24'd0, 24'd0);

    all_ones = '1;
    load_calibration(seal(all_ones, 1'b0));
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(24'd1, 24'd1);
    send_pair(24'd1, RAW_MAX);
    send_pair(RAW_MAX, 24'd1);

    // A broken CRC wins over a zero raw value.
    load_calibration(seal(typical, 1'b1));
    send_pair(24'd8569781, 24'd9085466);
    send_pair(24'd0, 24'd0);
    send_pair(24'd0, 24'd77);

    for (int s = 0; s < RANDOM_SETS; s++) begin
      for (int i = 0; i < bc_pkg::NUM_WORDS; i++) rand_set[i] = rand_word();
      load_calibration(seal(rand_set, $urandom_range(0, 6) == 0));
      repeat (PAIRS_PER_SET) raw_pairs.push_back(random_pair());
    end

    while (!drained()) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d readings across %0d calibration sets plus the reset set",
             readings_checked, calib_sets);
    $display("status mix: %0d compensated, %0d calibration CRC errors, %0d zero raw values",
             ok_count, crc_count, zero_count);
    if (bad_readings == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d readings differed from the prediction", bad_readings);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
